>>> design/rrts_pkg.sv
`default_nettype none
package rrts_pkg;
    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_STEP  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    localparam logic [1:0] KIND_SLICE = 2'd0;
    localparam logic [1:0] KIND_WAIT  = 2'd1;
    localparam logic [1:0] KIND_TOTAL = 2'd2;

    localparam int TIME_BITS  = 20;
    localparam int TOTAL_BITS = 24;
    localparam int AVG_BITS   = 28;
    localparam logic [TIME_BITS-1:0]  TIME_MAX  = '1;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
endpackage
`default_nettype wire

>>> design/rrts_if.sv
`default_nettype none
// Request channel.
interface rrts_req_if #(parameter int BURST_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic [1:0]            req_type;
    logic [BURST_BITS-1:0] burst_time;
    modport source (output valid, req_type, burst_time, input ready);
    modport sink   (input valid, req_type, burst_time, output ready);
endinterface

// Report channel.
interface rrts_rep_if;
    logic        valid;
    logic        ready;
    logic [1:0]  report_kind;
    logic [3:0]  task_index;
    logic [23:0] time_value;
    logic [27:0] average_wait;
    logic        last_of_run;
    modport source (output valid, report_kind, task_index, time_value, average_wait,
                    last_of_run, input ready);
    modport sink   (input valid, report_kind, task_index, time_value, average_wait,
                    last_of_run, output ready);
endinterface

// Configuration write channel.
interface rrts_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

>>> design/round_robin_time_slice_scheduler.sv
`default_nettype none
// Round-robin time-slice scheduler. Task state (remaining work, last slice end,
// waiting total) lives in one single-port task memory with a registered read.
// A load writes its entry straight from idle. A clear sweeps the memory, one
// entry a cycle, before the next request is taken. A step that grants a slice
// visits one task per memory read, then writes the entry back and emits. The
// final report reads each task in turn and then runs a bit-serial divide for
// the average. The memory is cleared after reset before the first request is
// taken. The next request is taken once the last word of the current one has
// been handed off.
module round_robin_time_slice_scheduler #(
    parameter int MAX_PROCESSES = 16,
    parameter int BURST_BITS    = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    rrts_cfg_if.sink   cfg,
    rrts_req_if.sink   req,
    rrts_rep_if.source rep
);
    import rrts_pkg::*;

    localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CW = $clog2(MAX_PROCESSES + 1);
    localparam int EW = BURST_BITS + 2 * TIME_BITS;
    localparam int DW = TOTAL_BITS + 8;

    typedef enum logic [3:0] {
        S_SWEEP, S_IDLE, S_SRD, S_SCHK, S_SWR, S_RRD, S_RCHK, S_DIV, S_OUT
    } t_state;

    // task memory: {remaining, last_end, waiting}
    logic [EW-1:0] mem [MAX_PROCESSES];
    logic [EW-1:0] r_rd;
    logic [IW-1:0] mem_addr;
    logic          mem_we;
    logic [EW-1:0] mem_wd;

    t_state          r_state;
    logic [15:0]     r_quantum;
    logic [TIME_BITS-1:0] r_now;
    logic [IW-1:0]   r_next;
    logic [CW-1:0]   r_count;
    logic [IW-1:0]   r_idx;
    logic [CW-1:0]   r_k;
    logic [TOTAL_BITS-1:0] r_total;
    logic [DW-1:0]   r_num;
    logic [DW-1:0]   r_quo;
    logic [CW-1:0]   r_rem;
    logic [5:0]      r_bit;
    logic            r_req_ready;
    logic            r_out_valid;
    logic [1:0]      r_kind;
    logic [3:0]      r_tidx;
    logic [23:0]     r_tval;
    logic [27:0]     r_avg;
    logic            r_last;

    // entry fields of the read word
    logic [BURST_BITS-1:0] rd_rem;
    logic [TIME_BITS-1:0]  rd_end, rd_wait;
    assign rd_rem  = r_rd[EW-1 -: BURST_BITS];
    assign rd_end  = r_rd[2*TIME_BITS-1 -: TIME_BITS];
    assign rd_wait = r_rd[TIME_BITS-1:0];

    // slice arithmetic
    logic [15:0]           q_eff;
    logic [BURST_BITS-1:0] slice;
    logic [TIME_BITS:0]    wait_sum, now_sum;
    logic [TIME_BITS-1:0]  wait_new, now_new;
    always_comb begin
        q_eff = (r_quantum == 16'd0) ? 16'd1 : r_quantum;
        if ({16'd0, rd_rem} < {{BURST_BITS{1'b0}}, q_eff})
            slice = rd_rem;
        else
            slice = BURST_BITS'({16'd0, q_eff});
        wait_sum = {1'b0, rd_wait} + {1'b0, r_now - rd_end};
        wait_new = wait_sum[TIME_BITS] ? TIME_MAX : wait_sum[TIME_BITS-1:0];
        now_sum  = {1'b0, r_now} + (TIME_BITS+1)'(slice);
        now_new  = now_sum[TIME_BITS] ? TIME_MAX : now_sum[TIME_BITS-1:0];
    end

    logic [TOTAL_BITS:0] tot_sum;
    assign tot_sum = {1'b0, r_total} + (TOTAL_BITS+1)'(rd_wait);

    logic [IW-1:0] idx_inc;
    assign idx_inc = ({1'b0, r_idx} + 1'b1 >= (IW+1)'(r_count)) ? '0 : r_idx + 1'b1;

    logic [CW:0] rem_sh;
    assign rem_sh = {r_rem, r_num[DW-1]};

    logic req_fire, out_fire;
    assign req_fire = req.valid && r_req_ready;
    assign out_fire = r_out_valid && rep.ready;

    // memory port control
    always_comb begin
        mem_we   = 1'b0;
        mem_addr = r_idx;
        mem_wd   = '0;
        unique case (r_state)
            S_SWEEP: mem_we = 1'b1;
            S_IDLE: begin
                mem_addr = r_count[IW-1:0];
                mem_wd   = {req.burst_time, {2*TIME_BITS{1'b0}}};
                mem_we   = req_fire && (req.req_type == REQ_LOAD) &&
                           (r_count < CW'(MAX_PROCESSES));
            end
            S_SWR: begin
                mem_we = 1'b1;
                mem_wd = {rd_rem - slice, now_new, wait_new};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= mem_wd;
        r_rd <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_quantum   <= 16'd4;
            r_now       <= '0;
            r_next      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_req_ready <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg.valid) r_quantum <= cfg.data;
            if (out_fire) r_out_valid <= 1'b0;
            unique case (r_state)
                S_SWEEP: begin
                    if (32'(r_idx) == MAX_PROCESSES - 1) begin
                        r_idx       <= '0;
                        r_state     <= S_IDLE;
                        r_req_ready <= 1'b1;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (req_fire) begin
                        unique case (t_req'(req.req_type))
                            REQ_LOAD: begin
                                if (r_count < CW'(MAX_PROCESSES))
                                    r_count <= r_count + 1'b1;
                            end
                            REQ_CLEAR: begin
                                r_now       <= '0;
                                r_next      <= '0;
                                r_count     <= '0;
                                r_idx       <= '0;
                                r_req_ready <= 1'b0;
                                r_state     <= S_SWEEP;
                            end
                            REQ_STEP: begin
                                r_req_ready <= 1'b0;
                                r_idx       <= r_next;
                                r_k         <= '0;
                                r_total     <= '0;
                                r_state     <= (r_count == '0) ? S_DIV : S_SRD;
                                r_num       <= '0;
                                r_rem       <= '0;
                                r_bit       <= (r_count == '0) ? 6'd32 : 6'd0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SRD: r_state <= S_SCHK;
                S_SCHK: begin
                    if (rd_rem != '0) begin
                        r_state <= S_SWR;
                    end else if (r_k + 1'b1 >= r_count) begin
                        r_idx   <= '0;
                        r_k     <= '0;
                        r_state <= S_RRD;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_idx   <= idx_inc;
                        r_state <= S_SRD;
                    end
                end
                S_SWR: begin
                    r_now       <= now_new;
                    r_next      <= idx_inc;
                    r_kind      <= KIND_SLICE;
                    r_tidx      <= 4'(r_idx);
                    r_tval      <= 24'(now_new);
                    r_avg       <= '0;
                    r_last      <= 1'b1;
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_RRD: if (!r_out_valid || out_fire) r_state <= S_RCHK;
                S_RCHK: begin
                    r_kind      <= KIND_WAIT;
                    r_tidx      <= 4'(r_idx);
                    r_tval      <= 24'(rd_wait);
                    r_avg       <= '0;
                    r_last      <= 1'b0;
                    r_out_valid <= 1'b1;
                    r_total     <= tot_sum[TOTAL_BITS] ? TOTAL_MAX
                                                       : tot_sum[TOTAL_BITS-1:0];
                    if (r_k + 1'b1 >= r_count) begin
                        r_state <= S_DIV;
                        r_num   <= {(tot_sum[TOTAL_BITS] ? TOTAL_MAX
                                     : tot_sum[TOTAL_BITS-1:0]), 8'd0};
                        r_rem   <= '0;
                        r_bit   <= '0;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RRD;
                    end
                end
                S_DIV: begin
                    if (r_bit != 6'd32) begin
                        // restoring divide, one quotient bit a cycle
                        r_num <= r_num << 1;
                        r_bit <= r_bit + 1'b1;
                        if (rem_sh >= {1'b0, r_count}) begin
                            r_rem <= CW'(rem_sh - {1'b0, r_count});
                            r_quo <= {r_quo[DW-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh[CW-1:0];
                            r_quo <= {r_quo[DW-2:0], 1'b0};
                        end
                    end else if (!r_out_valid) begin
                        r_kind      <= KIND_TOTAL;
                        r_tidx      <= '0;
                        r_tval      <= r_total;
                        r_avg       <= (r_count == '0) ? '0 : r_quo[AVG_BITS-1:0];
                        r_last      <= 1'b1;
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_fire) begin
                        r_state     <= S_IDLE;
                        r_req_ready <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign cfg.ready        = 1'b1;
    assign req.ready        = r_req_ready;
    assign rep.valid        = r_out_valid;
    assign rep.report_kind  = r_kind;
    assign rep.task_index   = r_tidx;
    assign rep.time_value   = r_tval;
    assign rep.average_wait = r_avg;
    assign rep.last_of_run  = r_last;
endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
module testbench;
    import rrts_pkg::*;

    localparam int NTASK = 16;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  idx;
        logic [23:0] tv;
        logic [27:0] avg;
        logic        last;
    } t_report;

    typedef struct {
        t_req        req;
        logic [15:0] burst;
        bit          typed;
        logic [1:0]  kind;
        logic [23:0] tv;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rrts_cfg_if                   cfg_bus ();
    rrts_req_if #(.BURST_BITS(16)) req_bus ();
    rrts_rep_if                   rep_bus ();

    round_robin_time_slice_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .cfg     (cfg_bus),
        .req     (req_bus),
        .rep     (rep_bus)
    );

    always #5 i_clk = ~i_clk;

    // Scheduler shadow state
    logic [15:0] quantum_q;
    logic [15:0] work_left[NTASK];
    logic [19:0] slice_end[NTASK];
    logic [19:0] wait_sum[NTASK];
    logic [19:0] now_q;
    logic [3:0]  rr_ptr;
    logic [4:0]  n_tasks;

    t_report expected_reports[$];
    int      n_errors = 0;
    int      n_sent = 0;
    bit      quiet_mode = 0;

    function automatic void wipe_schedule();
        for (int i = 0; i < NTASK; i++) begin
            work_left[i] = '0;
            slice_end[i] = '0;
            wait_sum[i] = '0;
        end
        now_q = '0;
        rr_ptr = '0;
        n_tasks = '0;
    endfunction

    function automatic bit all_work_done();
        for (int i = 0; i < n_tasks; i++)
            if (work_left[i] != 0) return 0;
        return 1;
    endfunction

    // Advance the schedule by one request and queue the reports it yields
    function automatic void schedule_request(t_req req, logic [15:0] burst);
        t_report r;
        longint  q, slice, gap, sum;
        int      id;
        if (req == REQ_LOAD) begin
            if (n_tasks < NTASK) begin
                work_left[n_tasks] = burst;
                slice_end[n_tasks] = '0;
                wait_sum[n_tasks] = '0;
                n_tasks++;
            end
            return;
        end
        if (req == REQ_CLEAR) begin
            wipe_schedule();
            return;
        end
        if (req != REQ_STEP) return;
        for (int k = 0; k < n_tasks; k++) begin
            id = (rr_ptr + k) % n_tasks;
            if (work_left[id] != 0) begin
                q = (quantum_q == 0) ? 1 : quantum_q;
                slice = (work_left[id] < q) ? work_left[id] : q;
                gap = longint'(wait_sum[id]) + now_q - slice_end[id];
                wait_sum[id] = (gap > TIME_MAX) ? TIME_MAX : gap[19:0];
                gap = longint'(now_q) + slice;
                now_q = (gap > TIME_MAX) ? TIME_MAX : gap[19:0];
                slice_end[id] = now_q;
                work_left[id] = work_left[id] - slice[15:0];
                rr_ptr = (id + 1 >= n_tasks) ? 4'd0 : 4'(id + 1);
                r = '{KIND_SLICE, 4'(id), 24'(now_q), 28'd0, 1'b1};
                expected_reports.push_back(r);
                return;
            end
        end
        // every task finished: per-task waits, then total and average
        sum = 0;
        for (int k = 0; k < n_tasks; k++) begin
            r = '{KIND_WAIT, 4'(k), 24'(wait_sum[k]), 28'd0, 1'b0};
            expected_reports.push_back(r);
            sum += wait_sum[k];
        end
        if (sum > TOTAL_MAX) sum = TOTAL_MAX;
        r = '{KIND_TOTAL, 4'd0, 24'(sum),
              28'((n_tasks != 0) ? (sum << 8) / n_tasks : 0), 1'b1};
        expected_reports.push_back(r);
    endfunction

    function automatic int pick_gap();
        int p;
        if (quiet_mode) return 0;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one request word and wait for it to be taken
    task automatic issue(t_req req, logic [15:0] burst);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.req_type <= req;
        req_bus.burst_time <= burst;
        do @(posedge i_clk); while (!req_bus.ready);
        schedule_request(req, burst);
        n_sent++;
    endtask

    // Quantum write, only with the block idle
    task automatic set_quantum(logic [15:0] q);
        req_bus.valid <= 1'b0;
        wait (expected_reports.size() == 0);
        repeat (80) @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data <= q;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        quantum_q = q;
    endtask

    // Step until the final report comes out, with some noise mixed in
    task automatic run_to_report();
        int p;
        while (!all_work_done()) begin
            p = $urandom_range(0, 99);
            if (p < 3) issue(REQ_NONE, 16'($urandom()));
            else if (p < 5) issue(REQ_LOAD, 16'($urandom_range(0, 15)));
            else if (p == 5) issue(REQ_CLEAR, 16'($urandom()));
            else issue(REQ_STEP, 16'($urandom()));
        end
        repeat ($urandom_range(1, 2)) issue(REQ_STEP, 16'($urandom()));
    endtask

    // Report checker
    always @(posedge i_clk) begin
        t_report got, want;
        if (i_rst_n && rep_bus.valid && rep_bus.ready) begin
            got = '{rep_bus.report_kind, rep_bus.task_index, rep_bus.time_value,
                    rep_bus.average_wait, rep_bus.last_of_run};
            if (expected_reports.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected report kind=%0d task=%0d time=%0d avg=%0d last=%0d",
                             got.kind, got.idx, got.tv, got.avg, got.last);
            end else begin
                want = expected_reports.pop_front();
                if (got != want) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("report mismatch exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                                 want.kind, want.idx, want.tv, want.avg, want.last,
                                 got.kind, got.idx, got.tv, got.avg, got.last);
                end
            end
        end
    end

    // Report sink: random stalls, one long hold-off once the run is underway
    initial begin
        bit held;
        held = 0;
        rep_bus.ready <= 1'b0;
        forever begin
            if (!held && n_sent > 150) begin
                held = 1;
                rep_bus.ready <= 1'b0;
                repeat (500) @(posedge i_clk);
            end
            rep_bus.ready <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
            rep_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    // Directed rows at the reset quantum of 4
    t_row directed[] = '{
        '{REQ_STEP,  16'd0,     1, KIND_TOTAL, 24'd0},
        '{REQ_LOAD,  16'd5,     0, KIND_SLICE, 24'd0},
        '{REQ_LOAD,  16'd0,     0, KIND_SLICE, 24'd0},
        '{REQ_LOAD,  16'd3,     0, KIND_SLICE, 24'd0},
        '{REQ_STEP,  16'hffff,  1, KIND_SLICE, 24'd4},
        '{REQ_STEP,  16'd0,     1, KIND_SLICE, 24'd7},
        '{REQ_NONE,  16'hffff,  0, KIND_SLICE, 24'd0},
        '{REQ_STEP,  16'd0,     1, KIND_SLICE, 24'd8},
        '{REQ_STEP,  16'd0,     0, KIND_SLICE, 24'd0},
        '{REQ_STEP,  16'd0,     0, KIND_SLICE, 24'd0},
        '{REQ_CLEAR, 16'hffff,  0, KIND_SLICE, 24'd0},
        '{REQ_STEP,  16'd0,     1, KIND_TOTAL, 24'd0},
        '{REQ_LOAD,  16'd1,     0, KIND_SLICE, 24'd0},
        '{REQ_STEP,  16'd0,     1, KIND_SLICE, 24'd1},
        '{REQ_STEP,  16'd0,     1, KIND_WAIT,  24'd0}
    };

    initial begin
        int n, ph;
        req_bus.valid <= 1'b0;
        req_bus.req_type <= REQ_NONE;
        req_bus.burst_time <= '0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.data <= '0;
        quantum_q = 16'd4;
        wipe_schedule();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            // typed rows look at the first word of their own request
            if (directed[i].typed) begin
                req_bus.valid <= 1'b0;
                wait (expected_reports.size() == 0);
            end
            n = expected_reports.size();
            issue(directed[i].req, directed[i].burst);
            if (directed[i].typed &&
                (expected_reports[n].kind != directed[i].kind ||
                 expected_reports[n].tv != directed[i].tv)) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("directed row %0d: schedule gives kind=%0d time=%0d",
                             i, expected_reports[n].kind, expected_reports[n].tv);
            end
        end

        // sixteen full bursts at the largest quantum, then overflow loads
        set_quantum(16'hffff);
        issue(REQ_CLEAR, 16'd0);
        repeat (18) issue(REQ_LOAD, 16'hffff);
        run_to_report();

        // zero quantum acts as one
        set_quantum(16'd0);
        issue(REQ_CLEAR, 16'd0);
        repeat (3) issue(REQ_LOAD, 16'($urandom_range(0, 4)));
        run_to_report();

        ph = 0;
        while (n_sent < 400) begin
            quiet_mode = (ph % 5 == 3);
            case ($urandom_range(0, 2))
                0: begin
                    set_quantum(16'($urandom_range(0, 6)));
                    issue(REQ_CLEAR, 16'($urandom()));
                    repeat ($urandom_range(0, 18)) issue(REQ_LOAD, 16'($urandom_range(0, 7)));
                end
                1: begin
                    set_quantum(16'hffff);
                    issue(REQ_CLEAR, 16'($urandom()));
                    repeat ($urandom_range(1, 17)) issue(REQ_LOAD, 16'($urandom()));
                end
                default: begin
                    set_quantum(16'($urandom_range(256, 4096)));
                    issue(REQ_CLEAR, 16'($urandom()));
                    repeat ($urandom_range(1, 4)) issue(REQ_LOAD, 16'($urandom_range(0, 2000)));
                end
            endcase
            run_to_report();
            ph++;
        end
        quiet_mode = 0;
        req_bus.valid <= 1'b0;

        wait (expected_reports.size() == 0);
        repeat (200) @(posedge i_clk);
        if (n_errors == 0 && expected_reports.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

>>> files.f
design/rrts_pkg.sv
design/rrts_if.sv
design/round_robin_time_slice_scheduler.sv
tb/sv/testbench.sv
